[hdl/segx_pkg.sv]
// request mode codes shared by the segment intersection block
package segx_pkg;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_STRICT = 2'd0;
    localparam mode_t MODE_INCL   = 2'd1;
    localparam mode_t MODE_LINE   = 2'd2;

endpackage

[hdl/segment_intersection_2d.sv]
// pipelined 2d segment intersection with exact determinants and a pipelined divider
// done follows start through the stage 1 to 4 registers, the divider entry and bit stages and the done register
// throughput: one word per cycle; busy is held low, the pipeline never stalls
// the quotient a0 + v*fa/d comes from a restoring divider of COORD_BITS+FRAC_BITS+2 stages
// reset: rst_n clears all valid bits asynchronously; no word is in flight afterwards
// results appear for one cycle with done high and cannot be held off
module segment_intersection_2d #(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            req_type,
    input  logic signed [COORD_BITS-1:0]          seg_a_x0,
    input  logic signed [COORD_BITS-1:0]          seg_a_y0,
    input  logic signed [COORD_BITS-1:0]          seg_a_x1,
    input  logic signed [COORD_BITS-1:0]          seg_a_y1,
    input  logic signed [COORD_BITS-1:0]          seg_b_x0,
    input  logic signed [COORD_BITS-1:0]          seg_b_y0,
    input  logic signed [COORD_BITS-1:0]          seg_b_x1,
    input  logic signed [COORD_BITS-1:0]          seg_b_y1,
    output logic                                  done,
    output logic                                  hit,
    output logic                                  is_parallel,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] cross_x,
    output logic signed [COORD_BITS+FRAC_BITS-1:0] cross_y,
    output logic                                  clamped
);

    localparam int C   = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int OW  = C + F;
    localparam int DFW = C + 1;
    localparam int PW  = 2 * C + 2;
    localparam int DW  = 2 * C + 3;
    localparam int MW  = 2 * C + 2;
    localparam int VW  = C + 1;
    localparam int NW  = MW + VW + F;
    localparam int QB  = C + F + 2;
    localparam int RW  = MW + 1;
    localparam int SW  = QB + 3;
    localparam logic signed [SW-1:0] OMAX = SW'((64'sd1 <<< (OW - 1)) - 64'sd1);
    localparam logic signed [SW-1:0] OMIN = SW'(-(64'sd1 <<< (OW - 1)));

    typedef logic signed [C-1:0] crd_t;

    typedef struct packed {
        logic                 hit;
        logic                 comp;
        logic                 par;
        logic                 ovf_x;
        logic                 ovf_y;
        logic                 neg_x;
        logic                 neg_y;
        crd_t                 bx;
        crd_t                 by;
        logic signed [OW-1:0] px;
        logic signed [OW-1:0] py;
    } side_t;

    assign busy = 1'b0;

    // stage 1: input register
    logic          v1_reg;
    segx_pkg::mode_t md1_reg;
    crd_t          ax0_reg, ay0_reg, ax1_reg, ay1_reg;
    crd_t          bx0_reg, by0_reg, bx1_reg, by1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= start;
        end
    end

    always_ff @(posedge clk)
    begin
        md1_reg <= req_type;
        ax0_reg <= seg_a_x0;
        ay0_reg <= seg_a_y0;
        ax1_reg <= seg_a_x1;
        ay1_reg <= seg_a_y1;
        bx0_reg <= seg_b_x0;
        by0_reg <= seg_b_y0;
        bx1_reg <= seg_b_x1;
        by1_reg <= seg_b_y1;
    end

    // stage 2: differences and products
    logic signed [DFW-1:0] vx, vy, wx, wy, ox, oy;
    crd_t                  s0x [4], s0y [4], s1x [4], s1y [4], ptx [4], pty [4];
    logic signed [DFW-1:0] tux [4], tuy [4], twx [4], twy [4];

    assign vx = DFW'(ax1_reg) - DFW'(ax0_reg);
    assign vy = DFW'(ay1_reg) - DFW'(ay0_reg);
    assign wx = DFW'(bx0_reg) - DFW'(bx1_reg);
    assign wy = DFW'(by0_reg) - DFW'(by1_reg);
    assign ox = DFW'(bx0_reg) - DFW'(ax0_reg);
    assign oy = DFW'(by0_reg) - DFW'(ay0_reg);

    // endpoint tests in priority order: b start, b end, a start, a end
    always_comb
    begin
        s0x[0] = ax0_reg; s0y[0] = ay0_reg; s1x[0] = ax1_reg; s1y[0] = ay1_reg;
        ptx[0] = bx0_reg; pty[0] = by0_reg;
        s0x[1] = ax0_reg; s0y[1] = ay0_reg; s1x[1] = ax1_reg; s1y[1] = ay1_reg;
        ptx[1] = bx1_reg; pty[1] = by1_reg;
        s0x[2] = bx0_reg; s0y[2] = by0_reg; s1x[2] = bx1_reg; s1y[2] = by1_reg;
        ptx[2] = ax0_reg; pty[2] = ay0_reg;
        s0x[3] = bx0_reg; s0y[3] = by0_reg; s1x[3] = bx1_reg; s1y[3] = by1_reg;
        ptx[3] = ax1_reg; pty[3] = ay1_reg;
        for (int i = 0; i < 4; i++)
        begin
            tux[i] = DFW'(s0x[i]) - DFW'(ptx[i]);
            tuy[i] = DFW'(s0y[i]) - DFW'(pty[i]);
            twx[i] = DFW'(ptx[i]) - DFW'(s1x[i]);
            twy[i] = DFW'(pty[i]) - DFW'(s1y[i]);
        end
    end

    logic                  v2_reg;
    segx_pkg::mode_t       md2_reg;
    crd_t                  ax2_reg, ay2_reg, bx2_reg, by2_reg;
    crd_t                  px2_reg [4], py2_reg [4];
    logic signed [DFW-1:0] vx2_reg, vy2_reg;
    logic signed [PW-1:0]  pd0_reg, pd1_reg, pa0_reg, pa1_reg, pb0_reg, pb1_reg;
    logic signed [PW-1:0]  pt0_reg [4], pt1_reg [4], pt2_reg [4], pt3_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        md2_reg <= md1_reg;
        ax2_reg <= ax0_reg;
        ay2_reg <= ay0_reg;
        bx2_reg <= bx0_reg;
        by2_reg <= by0_reg;
        vx2_reg <= vx;
        vy2_reg <= vy;
        pd0_reg <= vx * wy;
        pd1_reg <= vy * wx;
        pa0_reg <= ox * wy;
        pa1_reg <= oy * wx;
        pb0_reg <= vx * oy;
        pb1_reg <= vy * ox;
        for (int i = 0; i < 4; i++)
        begin
            px2_reg[i] <= ptx[i];
            py2_reg[i] <= pty[i];
            pt0_reg[i] <= tux[i] * twy[i];
            pt1_reg[i] <= tuy[i] * twx[i];
            pt2_reg[i] <= tux[i] * twx[i];
            pt3_reg[i] <= tuy[i] * twy[i];
        end
    end

    // stage 3: determinants, sign normalised so that d >= 0
    logic signed [DW-1:0] d_raw, fa_raw, fb_raw;
    logic signed [DW-1:0] t_det [4], t_dot [4];
    logic [3:0]           on_seg;

    assign d_raw  = DW'(pd0_reg) - DW'(pd1_reg);
    assign fa_raw = DW'(pa0_reg) - DW'(pa1_reg);
    assign fb_raw = DW'(pb0_reg) - DW'(pb1_reg);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            t_det[i]  = DW'(pt0_reg[i]) - DW'(pt1_reg[i]);
            t_dot[i]  = DW'(pt2_reg[i]) + DW'(pt3_reg[i]);
            on_seg[i] = (t_det[i] == '0) && !t_dot[i][DW-1];
        end
    end

    logic                  v3_reg;
    segx_pkg::mode_t       md3_reg;
    crd_t                  ax3_reg, ay3_reg;
    crd_t                  px3_reg [4], py3_reg [4];
    logic signed [DFW-1:0] vx3_reg, vy3_reg;
    logic [MW-1:0]         dm3_reg;
    logic signed [DW-1:0]  fa3_reg, fb3_reg;
    logic [3:0]            os3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else
        begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        md3_reg <= md2_reg;
        ax3_reg <= ax2_reg;
        ay3_reg <= ay2_reg;
        vx3_reg <= vx2_reg;
        vy3_reg <= vy2_reg;
        for (int i = 0; i < 4; i++)
        begin
            px3_reg[i] <= px2_reg[i];
            py3_reg[i] <= py2_reg[i];
        end
        dm3_reg <= d_raw[DW-1] ? MW'(-d_raw) : MW'(d_raw);
        fa3_reg <= d_raw[DW-1] ? -fa_raw : fa_raw;
        fb3_reg <= d_raw[DW-1] ? -fb_raw : fb_raw;
        os3_reg <= on_seg;
    end

    // stage 4: mode decision and numerators
    logic signed [DW-1:0] dsg;
    logic                 touch, strict_ok, comp;
    crd_t                 tpx, tpy;
    logic [MW-1:0]        fa_mag;
    logic [VW-1:0]        vx_mag, vy_mag;

    assign dsg       = $signed({1'b0, dm3_reg});
    assign touch     = (md3_reg == segx_pkg::MODE_INCL) && (os3_reg != 4'b0000);
    assign strict_ok = (dm3_reg != '0) && (fa3_reg > 0) && (fa3_reg < dsg)
                       && (fb3_reg > 0) && (fb3_reg < dsg);
    assign comp      = (((md3_reg == segx_pkg::MODE_STRICT)
                         || ((md3_reg == segx_pkg::MODE_INCL) && !touch)) && strict_ok)
                       || ((md3_reg == segx_pkg::MODE_LINE) && (dm3_reg != '0));
    assign fa_mag    = fa3_reg[DW-1] ? MW'(-fa3_reg) : MW'(fa3_reg);
    assign vx_mag    = vx3_reg[DFW-1] ? VW'(-vx3_reg) : VW'(vx3_reg);
    assign vy_mag    = vy3_reg[DFW-1] ? VW'(-vy3_reg) : VW'(vy3_reg);

    always_comb
    begin
        if (os3_reg[0])
        begin
            tpx = px3_reg[0]; tpy = py3_reg[0];
        end
        else if (os3_reg[1])
        begin
            tpx = px3_reg[1]; tpy = py3_reg[1];
        end
        else if (os3_reg[2])
        begin
            tpx = px3_reg[2]; tpy = py3_reg[2];
        end
        else
        begin
            tpx = px3_reg[3]; tpy = py3_reg[3];
        end
    end

    logic          v4_reg;
    side_t         sd4_reg;
    logic [NW-1:0] nx4_reg, ny4_reg;
    logic [MW-1:0] dm4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sd4_reg.hit   <= touch || comp;
        sd4_reg.comp  <= comp;
        sd4_reg.par   <= (dm3_reg == '0);
        sd4_reg.ovf_x <= 1'b0;
        sd4_reg.ovf_y <= 1'b0;
        sd4_reg.neg_x <= fa3_reg[DW-1] ^ vx3_reg[DFW-1];
        sd4_reg.neg_y <= fa3_reg[DW-1] ^ vy3_reg[DFW-1];
        sd4_reg.bx    <= ax3_reg;
        sd4_reg.by    <= ay3_reg;
        sd4_reg.px    <= touch ? (OW'(tpx) <<< F) : '0;
        sd4_reg.py    <= touch ? (OW'(tpy) <<< F) : '0;
        nx4_reg       <= (NW'(fa_mag) * NW'(vx_mag)) << F;
        ny4_reg       <= (NW'(fa_mag) * NW'(vy_mag)) << F;
        dm4_reg       <= dm3_reg;
    end

    // divider: entry stage checks quotient range, then one quotient bit per stage
    logic          dv_reg [QB+1];
    side_t         ds_reg [QB+1];
    logic [MW-1:0] dd_reg [QB+1];
    logic [MW-1:0] rx_reg [QB+1], ry_reg [QB+1];
    logic [QB-1:0] lx_reg [QB+1], ly_reg [QB+1];
    logic [QB-1:0] qx_reg [QB+1], qy_reg [QB+1];

    logic [NW-1:0] hx, hy;
    side_t         sd_in;

    assign hx = nx4_reg >> QB;
    assign hy = ny4_reg >> QB;

    always_comb
    begin
        sd_in       = sd4_reg;
        sd_in.ovf_x = (hx >= NW'(dm4_reg));
        sd_in.ovf_y = (hy >= NW'(dm4_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= QB; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
        end
        else
        begin
            dv_reg[0] <= v4_reg;
            for (int k = 0; k < QB; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ds_reg[0] <= sd_in;
        dd_reg[0] <= dm4_reg;
        rx_reg[0] <= MW'(hx);
        ry_reg[0] <= MW'(hy);
        lx_reg[0] <= nx4_reg[QB-1:0];
        ly_reg[0] <= ny4_reg[QB-1:0];
        qx_reg[0] <= '0;
        qy_reg[0] <= '0;
    end

    for (genvar k = 0; k < QB; k++)
    begin : g_div
        logic [RW-1:0] tx, ty;
        logic          gx, gy;

        assign tx = {rx_reg[k], lx_reg[k][QB-1]};
        assign ty = {ry_reg[k], ly_reg[k][QB-1]};
        assign gx = (tx >= RW'(dd_reg[k]));
        assign gy = (ty >= RW'(dd_reg[k]));

        always_ff @(posedge clk)
        begin
            ds_reg[k+1] <= ds_reg[k];
            dd_reg[k+1] <= dd_reg[k];
            rx_reg[k+1] <= gx ? MW'(tx - RW'(dd_reg[k])) : MW'(tx);
            ry_reg[k+1] <= gy ? MW'(ty - RW'(dd_reg[k])) : MW'(ty);
            lx_reg[k+1] <= lx_reg[k] << 1;
            ly_reg[k+1] <= ly_reg[k] << 1;
            qx_reg[k+1] <= {qx_reg[k][QB-2:0], gx};
            qy_reg[k+1] <= {qy_reg[k][QB-2:0], gy};
        end
    end

    // final stage: floor, add base, saturate
    side_t                sf;
    logic signed [SW-1:0] qsx, qsy, rsx, rsy;
    logic signed [OW-1:0] ox_fin, oy_fin;
    logic                 satx, saty;

    assign sf = ds_reg[QB];

    always_comb
    begin
        qsx = sf.neg_x ? -(SW'(qx_reg[QB]) + SW'(rx_reg[QB] != '0)) : SW'(qx_reg[QB]);
        qsy = sf.neg_y ? -(SW'(qy_reg[QB]) + SW'(ry_reg[QB] != '0)) : SW'(qy_reg[QB]);
        rsx = qsx + (SW'(sf.bx) <<< F);
        rsy = qsy + (SW'(sf.by) <<< F);

        satx = 1'b1;
        if (sf.ovf_x)
        begin
            ox_fin = sf.neg_x ? OW'(OMIN) : OW'(OMAX);
        end
        else if (rsx > OMAX)
        begin
            ox_fin = OW'(OMAX);
        end
        else if (rsx < OMIN)
        begin
            ox_fin = OW'(OMIN);
        end
        else
        begin
            ox_fin = OW'(rsx);
            satx   = 1'b0;
        end

        saty = 1'b1;
        if (sf.ovf_y)
        begin
            oy_fin = sf.neg_y ? OW'(OMIN) : OW'(OMAX);
        end
        else if (rsy > OMAX)
        begin
            oy_fin = OW'(OMAX);
        end
        else if (rsy < OMIN)
        begin
            oy_fin = OW'(OMIN);
        end
        else
        begin
            oy_fin = OW'(rsy);
            saty   = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done <= 1'b0;
        end
        else
        begin
            done <= dv_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        hit         <= sf.hit;
        is_parallel <= sf.par;
        cross_x     <= sf.comp ? ox_fin : sf.px;
        cross_y     <= sf.comp ? oy_fin : sf.py;
        clamped     <= sf.comp && (satx || saty);
    end

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the segment intersection block
module tb_top;

    localparam int CB = 16;
    localparam int FB = 8;
    localparam int OB = CB + FB;
    localparam int N_RANDOM = 1900;

    typedef struct {
        logic [1:0]        mode;
        logic signed [CB-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
    } seg_word_t;

    typedef struct {
        logic              hit;
        logic              par;
        logic [OB-1:0]     cx;
        logic [OB-1:0]     cy;
        logic              sat;
    } cross_word_t;

    typedef struct {
        seg_word_t   w;
        bit          typed;
        cross_word_t r;
    } dir_row_t;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic [1:0] req_type;
    logic signed [CB-1:0] seg_a_x0, seg_a_y0, seg_a_x1, seg_a_y1;
    logic signed [CB-1:0] seg_b_x0, seg_b_y0, seg_b_x1, seg_b_y1;
    logic done, hit, is_parallel, clamped;
    logic signed [OB-1:0] cross_x, cross_y;

    cross_word_t pending_cross[$];
    int errors = 0;

    segment_intersection_2d #(.COORD_BITS(CB), .FRAC_BITS(FB)) u_dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
        .req_type(req_type),
        .seg_a_x0(seg_a_x0), .seg_a_y0(seg_a_y0),
        .seg_a_x1(seg_a_x1), .seg_a_y1(seg_a_y1),
        .seg_b_x0(seg_b_x0), .seg_b_y0(seg_b_y0),
        .seg_b_x1(seg_b_x1), .seg_b_y1(seg_b_y1),
        .done(done), .hit(hit), .is_parallel(is_parallel),
        .cross_x(cross_x), .cross_y(cross_y), .clamped(clamped)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4000000;
        $display("tb_top NOT OK");
        $finish;
    end

    // floor(num*v*2^FB/den) + base*2^FB, den > 0, saturated to the output range
    function automatic longint scaled_point(longint num, longint v, longint den, longint base,
                                            inout bit sat);
        longint lim;
        logic signed [127:0] p, q, r, dd;
        longint res;
        lim = longint'(1) << (OB - 1);
        p = 128'(num) * 128'(v) * (128'sd1 <<< FB);
        dd = den;
        q = p / dd;
        r = p % dd;
        if (r != 0 && p < 0)
            q = q - 1;
        q = q + 128'(base) * (128'sd1 <<< FB);
        if (q > lim - 1)
        begin
            res = lim - 1;
            sat = 1;
        end
        else if (q < -lim)
        begin
            res = -lim;
            sat = 1;
        end
        else
            res = longint'(q);
        return res;
    endfunction

    function automatic bit lies_on(longint s0x, longint s0y, longint s1x, longint s1y,
                                   longint px, longint py);
        longint ux, uy, wx, wy;
        ux = s0x - px; uy = s0y - py;
        wx = px - s1x; wy = py - s1y;
        return (ux * wy - uy * wx) == 0 && (ux * wx + uy * wy) >= 0;
    endfunction

    function automatic cross_word_t predict_cross(seg_word_t w);
        cross_word_t o;
        longint ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
        longint vx, vy, wx, wy, ox, oy, d, fa, fb, cx, cy, px, py;
        bit h, s, calc, touch;
        ax0 = w.ax0; ay0 = w.ay0; ax1 = w.ax1; ay1 = w.ay1;
        bx0 = w.bx0; by0 = w.by0; bx1 = w.bx1; by1 = w.by1;
        vx = ax1 - ax0; vy = ay1 - ay0;
        wx = bx0 - bx1; wy = by0 - by1;
        ox = bx0 - ax0; oy = by0 - ay0;
        d = vx * wy - vy * wx;
        fa = ox * wy - oy * wx;
        fb = vx * oy - vy * ox;
        h = 0; s = 0; calc = 0; cx = 0; cy = 0;
        if (d < 0)
        begin
            d = -d; fa = -fa; fb = -fb;
        end
        if (w.mode == segx_pkg::MODE_INCL)
        begin
            touch = 1;
            px = 0; py = 0;
            if (lies_on(ax0, ay0, ax1, ay1, bx0, by0))
            begin
                px = bx0; py = by0;
            end
            else if (lies_on(ax0, ay0, ax1, ay1, bx1, by1))
            begin
                px = bx1; py = by1;
            end
            else if (lies_on(bx0, by0, bx1, by1, ax0, ay0))
            begin
                px = ax0; py = ay0;
            end
            else if (lies_on(bx0, by0, bx1, by1, ax1, ay1))
            begin
                px = ax1; py = ay1;
            end
            else
                touch = 0;
            if (touch)
            begin
                h = 1;
                cx = px * (longint'(1) << FB);
                cy = py * (longint'(1) << FB);
            end
        end
        if ((w.mode == segx_pkg::MODE_STRICT || (w.mode == segx_pkg::MODE_INCL && !h)) &&
            d != 0 && fa > 0 && fa < d && fb > 0 && fb < d)
            calc = 1;
        if (w.mode == segx_pkg::MODE_LINE && d != 0)
            calc = 1;
        if (calc)
        begin
            h = 1;
            cx = scaled_point(fa, vx, d, ax0, s);
            cy = scaled_point(fa, vy, d, ay0, s);
        end
        o.hit = h;
        o.par = (d == 0);
        o.cx = cx[OB-1:0];
        o.cy = cy[OB-1:0];
        o.sat = s;
        return o;
    endfunction

    function automatic seg_word_t mk(logic [1:0] m, int a0, int a1, int a2, int a3,
                                     int b0, int b1, int b2, int b3);
        seg_word_t w;
        w.mode = m;
        w.ax0 = CB'(a0); w.ay0 = CB'(a1); w.ax1 = CB'(a2); w.ay1 = CB'(a3);
        w.bx0 = CB'(b0); w.by0 = CB'(b1); w.bx1 = CB'(b2); w.by1 = CB'(b3);
        return w;
    endfunction

    function automatic logic signed [CB-1:0] rnd_coord(int span);
        if (span == 0)
            return CB'($urandom);
        return CB'($urandom_range(2 * span) - span);
    endfunction

    function automatic seg_word_t rnd_word();
        seg_word_t w;
        int span;
        int k;
        span = ($urandom_range(3) == 0) ? 0 : (($urandom_range(1) == 0) ? 8 : 300);
        w.mode = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(2));
        w.ax0 = rnd_coord(span); w.ay0 = rnd_coord(span);
        w.ax1 = rnd_coord(span); w.ay1 = rnd_coord(span);
        w.bx0 = rnd_coord(span); w.by0 = rnd_coord(span);
        w.bx1 = rnd_coord(span); w.by1 = rnd_coord(span);
        k = $urandom_range(9);
        // push towards touching, collinear and degenerate cases
        if (k == 0)
        begin
            w.bx0 = w.ax0; w.by0 = w.ay0;
        end
        else if (k == 1)
        begin
            w.bx1 = CB'(w.ax0 + (w.ax1 - w.ax0) * 2);
            w.by1 = CB'(w.ay0 + (w.ay1 - w.ay0) * 2);
            w.bx0 = CB'(w.ax0 - (w.ax1 - w.ax0)); w.by0 = CB'(w.ay0 - (w.ay1 - w.ay0));
        end
        else if (k == 2)
        begin
            w.ax1 = w.ax0; w.ay1 = w.ay0;
        end
        else if (k == 3)
        begin
            w.bx0 = CB'((w.ax0 + w.ax1) / 2); w.by0 = CB'((w.ay0 + w.ay1) / 2);
        end
        return w;
    endfunction

    // idle start for a random number of cycles, if any
    task automatic gap();
        int n;
        n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(2);
        if ($urandom_range(3) == 0)
            n = 0;
        if (n > 0)
        begin
            start <= 1'b0;
            repeat (n) @(negedge clk);
        end
    endtask

    // drive a word at the falling edge, held until accepted
    task automatic send_word(seg_word_t w, bit typed, cross_word_t r);
        req_type <= w.mode;
        seg_a_x0 <= w.ax0; seg_a_y0 <= w.ay0; seg_a_x1 <= w.ax1; seg_a_y1 <= w.ay1;
        seg_b_x0 <= w.bx0; seg_b_y0 <= w.by0; seg_b_x1 <= w.bx1; seg_b_y1 <= w.by1;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_cross.push_back(typed ? r : predict_cross(w));
        @(negedge clk);
        if ($urandom_range(2) != 0)
            gap();
    endtask

    always @(posedge clk)
    begin
        cross_word_t e;
        if (rst_n && done)
        begin
            if (pending_cross.size() == 0)
            begin
                $display("%0t: unexpected word hit=%0b", $time, hit);
                errors++;
            end
            else
            begin
                e = pending_cross.pop_front();
                if (hit !== e.hit)
                begin
                    $display("%0t: hit exp %0b got %0b", $time, e.hit, hit);
                    errors++;
                end
                if (is_parallel !== e.par)
                begin
                    $display("%0t: is_parallel exp %0b got %0b", $time, e.par, is_parallel);
                    errors++;
                end
                if (cross_x !== e.cx)
                begin
                    $display("%0t: cross_x exp %h got %h", $time, e.cx, cross_x);
                    errors++;
                end
                if (cross_y !== e.cy)
                begin
                    $display("%0t: cross_y exp %h got %h", $time, e.cy, cross_y);
                    errors++;
                end
                if (clamped !== e.sat)
                begin
                    $display("%0t: clamped exp %0b got %0b", $time, e.sat, clamped);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        dir_row_t rows[$];
        dir_row_t row;
        cross_word_t z;
        int wait_cnt;
        start = 1'b0;
        req_type = '0;
        seg_a_x0 = '0; seg_a_y0 = '0; seg_a_x1 = '0; seg_a_y1 = '0;
        seg_b_x0 = '0; seg_b_y0 = '0; seg_b_x1 = '0; seg_b_y1 = '0;
        rst_n = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        z = '{hit: 0, par: 0, cx: '0, cy: '0, sat: 0};
        // plain crossing at (1,1), all modes, typed
        row.w = mk(segx_pkg::MODE_STRICT, 0, 0, 2, 2, 0, 2, 2, 0); row.typed = 1;
        row.r = '{1, 0, OB'(256), OB'(256), 0}; rows.push_back(row);
        row.w.mode = segx_pkg::MODE_INCL; rows.push_back(row);
        row.w.mode = segx_pkg::MODE_LINE; rows.push_back(row);
        // unused selector gives nothing
        row.w.mode = 2'd3; row.r = z; rows.push_back(row);
        // touching at b start: strict misses, inclusive returns the endpoint
        row.w = mk(segx_pkg::MODE_STRICT, 0, 0, 4, 0, 2, 0, 2, 5); row.r = z;
        rows.push_back(row);
        row.w.mode = segx_pkg::MODE_INCL; row.r = '{1, 0, OB'(512), OB'(0), 0};
        rows.push_back(row);
        // parallel lines
        row.w = mk(segx_pkg::MODE_LINE, 0, 0, 4, 0, 0, 1, 4, 1); row.r = '{0, 1, '0, '0, 0};
        rows.push_back(row);
        // degenerate segments
        row.w = mk(segx_pkg::MODE_INCL, 3, 3, 3, 3, 3, 3, 3, 3);
        row.r = '{1, 1, OB'(768), OB'(768), 0};
        rows.push_back(row);
        row.w = mk(segx_pkg::MODE_INCL, 3, 3, 3, 3, 4, 4, 4, 4); row.r = '{0, 1, '0, '0, 0};
        rows.push_back(row);
        row.typed = 0;
        // collinear overlap, extremes, line mode saturation
        row.w = mk(segx_pkg::MODE_INCL, 0, 0, 10, 0, 5, 0, 20, 0); rows.push_back(row);
        row.w = mk(segx_pkg::MODE_INCL, -32768, -32768, 32767, 32767,
                   -32768, 32767, 32767, -32768);
        rows.push_back(row);
        row.w.mode = segx_pkg::MODE_STRICT; rows.push_back(row);
        row.w = mk(segx_pkg::MODE_LINE, -32768, 0, 32767, 1, -32768, 1, 32767, 0);
        rows.push_back(row);
        row.w = mk(segx_pkg::MODE_LINE, 0, 0, 1, 0, 32767, -32768, 32766, 32767);
        rows.push_back(row);
        row.w = mk(segx_pkg::MODE_LINE, 0, 0, 32767, 1, 0, 1, 32767, 2); rows.push_back(row);
        row.w = mk(segx_pkg::MODE_LINE, 0, 0, -32768, 1, 0, 1, -32767, 1); rows.push_back(row);
        row.w = mk(segx_pkg::MODE_STRICT, -1, -1, -1, -1, -1, -1, -1, -1); rows.push_back(row);
        row.w = mk(segx_pkg::MODE_LINE, 0, 0, 3, 1, 0, 1, 1, -2); rows.push_back(row);
        row.w = mk(segx_pkg::MODE_STRICT, 0, 0, -3, 7, 1, 1, -5, 2); rows.push_back(row);

        foreach (rows[i])
            send_word(rows[i].w, rows[i].typed, rows[i].r);
        repeat (N_RANDOM)
            send_word(rnd_word(), 0, z);
        start <= 1'b0;

        wait_cnt = 0;
        while (pending_cross.size() != 0 && wait_cnt < 1000)
        begin
            @(posedge clk);
            wait_cnt++;
        end
        repeat (40) @(posedge clk);
        if (errors == 0 && pending_cross.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end
endmodule
